[rtl/mat4_vec4_transform_assert.svh]
// Assertion macros shared by the transform engine modules.
// Each use names its label, clock, active-low reset, trigger and expected condition.
`ifndef MAT4_VEC4_TRANSFORM_ASSERT_SVH
`define MAT4_VEC4_TRANSFORM_ASSERT_SVH

// Expected condition holds in the same cycle as the trigger.
`define M4V4_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Expected condition holds in the cycle after the trigger.
`define M4V4_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

[rtl/m4v4_pkg.sv]
`timescale 1ns / 1ps
package m4v4_pkg;

    localparam int NUM_LANES  = 4;
    localparam int NUM_COEF   = 16;
    localparam int COMP_W     = 32;
    localparam int PROD_W     = 64;
    localparam int PAIR_W     = 65;
    localparam int SUM_W      = 66;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 64;
    localparam int VEC_W      = NUM_LANES * COMP_W;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_comp COMP_MAX = 32'sh7FFF_FFFF;
    localparam t_comp COMP_MIN = 32'sh8000_0000;

    // Load enables for the three lane stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

[rtl/m4v4_lane.sv]
`timescale 1ns / 1ps
module m4v4_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  m4v4_pkg::t_stage_en i_en,
    input  m4v4_pkg::t_comp     i_coef [m4v4_pkg::NUM_LANES],
    input  m4v4_pkg::t_comp     i_vec  [m4v4_pkg::NUM_LANES],
    output m4v4_pkg::t_sum      o_sum
);

    localparam m4v4_pkg::t_pair RND = m4v4_pkg::t_pair'(1) << (FRAC_BITS - 1);

    m4v4_pkg::t_prod r_prod [m4v4_pkg::NUM_LANES];
    m4v4_pkg::t_pair r_pair_lo;
    m4v4_pkg::t_pair r_pair_hi;
    m4v4_pkg::t_sum  r_sum;

    // one multiplier per column of this row
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int k = 0; k < m4v4_pkg::NUM_LANES; k++) begin
                r_prod[k] <= m4v4_pkg::t_prod'($signed(i_coef[k]))
                           * m4v4_pkg::t_prod'($signed(i_vec[k]));
            end
        end
    end

    // fold the rounding half into the first pair
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_pair_lo <= m4v4_pkg::t_pair'(r_prod[0]) + m4v4_pkg::t_pair'(r_prod[1]) + RND;
            r_pair_hi <= m4v4_pkg::t_pair'(r_prod[2]) + m4v4_pkg::t_pair'(r_prod[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sum <= m4v4_pkg::t_sum'(r_pair_lo) + m4v4_pkg::t_sum'(r_pair_hi);
        end
    end

    assign o_sum = r_sum;

endmodule

[rtl/m4v4_merge.sv]
`timescale 1ns / 1ps
`include "mat4_vec4_transform_assert.svh"
module m4v4_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  m4v4_pkg::t_sum                  i_sum [m4v4_pkg::NUM_LANES],
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [m4v4_pkg::VEC_W-1:0]      o_m_tdata,   // out_x, out_y, out_z, out_w
    output logic                            o_m_tuser    // overflow
);

    m4v4_pkg::t_sum  w_q   [m4v4_pkg::NUM_LANES];
    m4v4_pkg::t_comp w_sat [m4v4_pkg::NUM_LANES];
    logic [m4v4_pkg::NUM_LANES-1:0] w_ovf;
    logic [m4v4_pkg::NUM_LANES-1:0] w_lim;
    logic                           w_at_limit;

    m4v4_pkg::t_comp r_out [m4v4_pkg::NUM_LANES];
    logic            r_ovf;
    logic            r_valid;

    for (genvar g = 0; g < m4v4_pkg::NUM_LANES; g++) begin : g_sat
        logic [m4v4_pkg::SUM_W-m4v4_pkg::COMP_W:0] w_top;
        assign w_q[g]   = i_sum[g] >>> FRAC_BITS;
        // value fits when all bits from the sign of the 32-bit range up agree
        assign w_top    = w_q[g][m4v4_pkg::SUM_W-1:m4v4_pkg::COMP_W-1];
        assign w_ovf[g] = !((&w_top) || !(|w_top));
        assign w_sat[g] = !w_ovf[g] ? w_q[g][m4v4_pkg::COMP_W-1:0]
                        : (w_q[g][m4v4_pkg::SUM_W-1] ? m4v4_pkg::COMP_MIN
                                                     : m4v4_pkg::COMP_MAX);
        assign w_lim[g] = (r_out[g] == m4v4_pkg::COMP_MAX)
                       || (r_out[g] == m4v4_pkg::COMP_MIN);
    end

    assign w_at_limit = |w_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < m4v4_pkg::NUM_LANES; k++) begin
                r_out[k] <= w_sat[k];
            end
            r_ovf <= |w_ovf;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_out[3], r_out[2], r_out[1], r_out[0]};
    assign o_m_tuser  = r_ovf;

    `M4V4_ASSERT_NOW(a_ovf_has_limit, i_clk, i_rst_n, r_valid && r_ovf, w_at_limit)

endmodule

[rtl/mat4_vec4_transform.sv]
`timescale 1ns / 1ps
`include "mat4_vec4_transform_assert.svh"
// 4x4 matrix by 4-vector transform, signed fixed point with FRAC_BITS fraction bits
// (8..24, Q16.16 by default). The matrix is column-major, coefficient c = row + 4*col,
// loaded as eight 64-bit pairs through the write port (low word = even coefficient);
// reset loads the identity. Write the matrix only while no vector is in flight.
// Mode 1 on tuser treats the input as a point with w = 1.0. Each output component is
// the exact four-term dot product, rounded half up and saturated to 32 bits; tuser on
// the output flags that any component saturated. Throughput is one vector per clock
// while the output is not stalled; the result passes through five register stages:
// input register, the sixteen 32x32 multipliers (four per row lane), two adder stages,
// and the saturating output register. Backpressure stalls only stages that hold data.
module mat4_vec4_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [m4v4_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [m4v4_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [m4v4_pkg::VEC_W-1:0]        i_s_tdata,   // in_x, in_y, in_z, in_w
    input  logic                              i_s_tuser,   // mode
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [m4v4_pkg::VEC_W-1:0]        o_m_tdata,   // out_x, out_y, out_z, out_w
    output logic                              o_m_tuser    // overflow
);

    localparam m4v4_pkg::t_comp ONE = m4v4_pkg::t_comp'(1) << FRAC_BITS;
    localparam int CW = m4v4_pkg::COMP_W;

    m4v4_pkg::t_comp r_coef [m4v4_pkg::NUM_COEF];
    m4v4_pkg::t_comp r_vec  [m4v4_pkg::NUM_LANES];
    logic r_vld0, r_vld1, r_vld2, r_vld3;

    logic w_out_free, w_rdy0, w_rdy1, w_rdy2, w_rdy3, w_s_xfer, w_load, w_stalled;
    m4v4_pkg::t_stage_en w_en;
    m4v4_pkg::t_comp     w_row_coef [m4v4_pkg::NUM_LANES][m4v4_pkg::NUM_LANES];
    m4v4_pkg::t_sum      w_sum      [m4v4_pkg::NUM_LANES];

    // coefficient store, identity after reset (diagonal: row equals column)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < m4v4_pkg::NUM_COEF; c++) begin
                r_coef[c] <= (c[1:0] == c[3:2]) ? ONE : '0;
            end
        end else if (i_cfg_we) begin
            r_coef[{i_cfg_index, 1'b0}] <= i_cfg_wdata[CW-1:0];
            r_coef[{i_cfg_index, 1'b1}] <= i_cfg_wdata[m4v4_pkg::CFG_W-1:CW];
        end
    end

    // a stage may load when it is empty or the stage after it can take its data
    assign w_out_free = !o_m_tvalid || i_m_tready;
    assign w_rdy3     = !r_vld3 || w_out_free;
    assign w_rdy2     = !r_vld2 || w_rdy3;
    assign w_rdy1     = !r_vld1 || w_rdy2;
    assign w_rdy0     = !r_vld0 || w_rdy1;
    assign o_s_tready = w_rdy0;
    assign w_s_xfer   = i_s_tvalid && w_rdy0;
    assign w_load     = r_vld3 && w_out_free;
    assign w_stalled  = r_vld0 && r_vld1 && r_vld2 && r_vld3 && o_m_tvalid && !i_m_tready;

    assign w_en.s1 = w_rdy1;
    assign w_en.s2 = w_rdy2;
    assign w_en.s3 = w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (w_rdy0) r_vld0 <= w_s_xfer;
            if (w_rdy1) r_vld1 <= r_vld0;
            if (w_rdy2) r_vld2 <= r_vld1;
            if (w_rdy3) r_vld3 <= r_vld2;
        end
    end

    // input register; point mode replaces w with 1.0
    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_vec[0] <= i_s_tdata[CW-1:0];
            r_vec[1] <= i_s_tdata[2*CW-1:CW];
            r_vec[2] <= i_s_tdata[3*CW-1:2*CW];
            r_vec[3] <= i_s_tuser ? ONE : i_s_tdata[4*CW-1:3*CW];
        end
    end

    for (genvar r = 0; r < m4v4_pkg::NUM_LANES; r++) begin : g_lane
        for (genvar k = 0; k < m4v4_pkg::NUM_LANES; k++) begin : g_col
            assign w_row_coef[r][k] = r_coef[r + m4v4_pkg::NUM_LANES * k];
        end

        m4v4_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_coef (w_row_coef[r]),
            .i_vec  (r_vec),
            .o_sum  (w_sum[r])
        );
    end

    m4v4_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_sum      (w_sum),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    `M4V4_ASSERT_NOW(a_full_when_blocked, i_clk, i_rst_n, !o_s_tready, w_stalled)
    `M4V4_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_vld0)
    `M4V4_ASSERT_NEXT(a_result_reaches_out, i_clk, i_rst_n, w_load, o_m_tvalid)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    localparam int FRAC_BITS = 16;
    localparam int NUM_PAIRS = 8;
    localparam int IDX_W = m4v4_pkg::CFG_IDX_W;
    localparam int PHASE_VECS = 205;
    localparam int DRAIN_CYCLES = 10;
    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_0000_8000_0000;
    localparam m4v4_pkg::t_comp ONE_FX = m4v4_pkg::t_comp'(1) <<< FRAC_BITS;
    localparam m4v4_pkg::t_comp HALF_FX = ONE_FX >>> 1;
    localparam m4v4_pkg::t_comp C_MAX = m4v4_pkg::COMP_MAX;
    localparam m4v4_pkg::t_comp C_MIN = m4v4_pkg::COMP_MIN;

    typedef enum logic {MODE_VEC = 1'b0, MODE_POINT = 1'b1} t_vec_mode;
    typedef enum {MAT_IDENT, MAT_HALF, MAT_MIN, MAT_MAX, MAT_SMALL, MAT_FULL, MAT_MIXED}
        t_mat_sel;

    typedef struct {
        m4v4_pkg::t_comp x;
        m4v4_pkg::t_comp y;
        m4v4_pkg::t_comp z;
        m4v4_pkg::t_comp w;
        logic            ovf;
    } t_vertex;

    typedef struct {
        t_mat_sel        mat;
        t_vec_mode       mode;
        m4v4_pkg::t_comp x;
        m4v4_pkg::t_comp y;
        m4v4_pkg::t_comp z;
        m4v4_pkg::t_comp w;
        bit              fixed;
        t_vertex         want;
    } t_vec_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [m4v4_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [m4v4_pkg::CFG_W-1:0]      i_cfg_wdata;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [m4v4_pkg::VEC_W-1:0]      i_s_tdata;   // in_x, in_y, in_z, in_w
    logic                            i_s_tuser;   // mode
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [m4v4_pkg::VEC_W-1:0]      o_m_tdata;   // out_x, out_y, out_z, out_w
    logic                            o_m_tuser;   // overflow

    logic [m4v4_pkg::CFG_W-1:0] matrix_regs [NUM_PAIRS];
    logic [m4v4_pkg::CFG_W-1:0] next_pairs [NUM_PAIRS];
    t_vertex          expected_vertices [$];
    t_vec_row         directed_rows [$];
    bit               stalls_on;
    int               err_count;

    mat4_vec4_transform #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic m4v4_pkg::t_comp coef_of(input int c);
        logic [m4v4_pkg::CFG_W-1:0] pair;
        pair = matrix_regs[c / 2];
        return (c % 2 != 0) ? m4v4_pkg::t_comp'(pair[63:32]) : m4v4_pkg::t_comp'(pair[31:0]);
    endfunction

    // Exact four-term dot product per row, round half up, saturate.
    function automatic t_vertex transform_vec(input logic mode, input m4v4_pkg::t_comp x,
                                              input m4v4_pkg::t_comp y,
                                              input m4v4_pkg::t_comp z,
                                              input m4v4_pkg::t_comp w);
        m4v4_pkg::t_comp     v [4];
        m4v4_pkg::t_comp     lanes [4];
        logic signed [127:0] acc;
        longint              prod;
        t_vertex             r;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        v[3] = (mode == MODE_POINT) ? ONE_FX : w;
        r.ovf = 1'b0;
        for (int row = 0; row < 4; row++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
                prod = longint'(coef_of(row + 4 * k)) * longint'(v[k]);
                acc = acc + prod;
            end
            acc = acc + (128'sd1 <<< (FRAC_BITS - 1));
            acc = acc >>> FRAC_BITS;
            if (acc > SAT_HI) begin
                lanes[row] = C_MAX;
                r.ovf = 1'b1;
            end else if (acc < SAT_LO) begin
                lanes[row] = C_MIN;
                r.ovf = 1'b1;
            end else begin
                lanes[row] = acc[31:0];
            end
        end
        r.x = lanes[0];
        r.y = lanes[1];
        r.z = lanes[2];
        r.w = lanes[3];
        return r;
    endfunction

    // Mostly small magnitudes, some extremes, some full range.
    function automatic m4v4_pkg::t_comp rand_comp();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return m4v4_pkg::t_comp'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            4, 5: return m4v4_pkg::t_comp'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: return m4v4_pkg::t_comp'($urandom);
        endcase
    endfunction

    function automatic void set_coef(input int c, input m4v4_pkg::t_comp val);
        if (c % 2 != 0)
            next_pairs[c / 2][63:32] = val;
        else
            next_pairs[c / 2][31:0] = val;
    endfunction

    function automatic void build_matrix(input t_mat_sel sel);
        for (int c = 0; c < 16; c++) begin
            case (sel)
                MAT_IDENT: set_coef(c, (c % 5 == 0) ? ONE_FX : 32'sd0);
                MAT_HALF:  set_coef(c, (c % 5 == 0) ? HALF_FX : 32'sd0);
                MAT_MIN:   set_coef(c, C_MIN);
                MAT_MAX:   set_coef(c, C_MAX);
                MAT_SMALL: set_coef(c, m4v4_pkg::t_comp'($urandom_range(0, 32'h0004_0000))
                                       - 32'sh0002_0000);
                MAT_FULL:  set_coef(c, m4v4_pkg::t_comp'($urandom));
                default:   set_coef(c, rand_comp());
            endcase
        end
    endfunction

    // Drop valid, let the pipeline empty, then load all eight pairs.
    task automatic write_matrix(input t_mat_sel sel);
        i_s_tvalid <= 1'b0;
        wait (expected_vertices.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        build_matrix(sel);
        for (int i = 0; i < NUM_PAIRS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= IDX_W'(i);
            i_cfg_wdata <= next_pairs[i];
            matrix_regs[i] = next_pairs[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Returns right after the edge that takes the transfer.
    task automatic push_vec(input t_vec_row row);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= row.mode;
        i_s_tdata  <= {row.w, row.z, row.y, row.x};
        do @(negedge i_clk); while (!o_s_tready);
        expected_vertices.push_back(row.fixed ? row.want
                                    : transform_vec(row.mode, row.x, row.y, row.z, row.w));
        @(posedge i_clk);
    endtask

    task automatic sender_gap();
        if (stalls_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= {$urandom, $urandom, $urandom, $urandom};
            i_s_tuser  <= 1'($urandom);
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input t_mat_sel mat, input t_vec_mode mode,
                           input m4v4_pkg::t_comp x, input m4v4_pkg::t_comp y,
                           input m4v4_pkg::t_comp z, input m4v4_pkg::t_comp w,
                           input bit fixed,
                           input m4v4_pkg::t_comp ox, input m4v4_pkg::t_comp oy,
                           input m4v4_pkg::t_comp oz, input m4v4_pkg::t_comp ow,
                           input logic ovf);
        t_vec_row row;
        row.mat = mat;
        row.mode = mode;
        row.x = x;
        row.y = y;
        row.z = z;
        row.w = w;
        row.fixed = fixed;
        row.want.x = ox;
        row.want.y = oy;
        row.want.z = oz;
        row.want.w = ow;
        row.want.ovf = ovf;
        directed_rows.push_back(row);
    endtask

    // Sink side: bursts of ready and stall.
    initial begin
        forever begin
            if (stalls_on && $urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    always @(negedge i_clk) begin : check_vertices
        t_vertex want;
        t_vertex got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x   = o_m_tdata[31:0];
            got.y   = o_m_tdata[63:32];
            got.z   = o_m_tdata[95:64];
            got.w   = o_m_tdata[127:96];
            got.ovf = o_m_tuser;
            if (expected_vertices.size() == 0) begin
                $error("output transfer with no vector pending");
                err_count++;
            end else begin
                want = expected_vertices.pop_front();
                if (got.x !== want.x) begin
                    $error("out_x: expected %h, got %h", want.x, got.x);
                    err_count++;
                end
                if (got.y !== want.y) begin
                    $error("out_y: expected %h, got %h", want.y, got.y);
                    err_count++;
                end
                if (got.z !== want.z) begin
                    $error("out_z: expected %h, got %h", want.z, got.z);
                    err_count++;
                end
                if (got.w !== want.w) begin
                    $error("out_w: expected %h, got %h", want.w, got.w);
                    err_count++;
                end
                if (got.ovf !== want.ovf) begin
                    $error("overflow: expected %b, got %b", want.ovf, got.ovf);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_mat_sel cur_mat;
        t_mat_sel phase_mats [6];
        t_vec_row row;
        stalls_on   = 1'b1;
        err_count   = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        // Shadow of the reset matrix: identity.
        build_matrix(MAT_IDENT);
        for (int i = 0; i < NUM_PAIRS; i++)
            matrix_regs[i] = next_pairs[i];
        cur_mat = MAT_IDENT;

        add_row(MAT_IDENT, MODE_VEC, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(MAT_IDENT, MODE_VEC, C_MAX, C_MIN, 1, -1, 1,
                C_MAX, C_MIN, 1, -1, 0);
        add_row(MAT_IDENT, MODE_POINT, C_MIN, C_MAX, -1, 32'sh1234_5678, 1,
                C_MIN, C_MAX, -1, ONE_FX, 0);
        add_row(MAT_IDENT, MODE_VEC, 32'sh0001_8000, -32'sh0002_4000, 32'sh5555_AAAA,
                32'shAAAA_5555, 0, 0, 0, 0, 0, 0);
        // Exact halves round toward plus infinity.
        add_row(MAT_HALF, MODE_VEC, 1, -1, 3, -3, 1, 1, 0, 2, -1, 0);
        add_row(MAT_HALF, MODE_VEC, C_MAX, C_MIN, 0, 0, 1,
                32'sh4000_0000, -32'sh4000_0000, 0, 0, 0);
        add_row(MAT_HALF, MODE_POINT, -5, 7, C_MIN, C_MAX, 0, 0, 0, 0, 0, 0);
        add_row(MAT_MIN, MODE_VEC, C_MAX, C_MAX, C_MAX, C_MAX, 1,
                C_MIN, C_MIN, C_MIN, C_MIN, 1);
        add_row(MAT_MIN, MODE_VEC, C_MIN, C_MIN, C_MIN, C_MIN, 1,
                C_MAX, C_MAX, C_MAX, C_MAX, 1);
        // Lands exactly on the negative limit: no saturation.
        add_row(MAT_MIN, MODE_POINT, 0, 0, 0, C_MAX, 1,
                C_MIN, C_MIN, C_MIN, C_MIN, 0);
        add_row(MAT_MIN, MODE_VEC, 1, 1, 1, 0, 1,
                -32'sd98304, -32'sd98304, -32'sd98304, -32'sd98304, 0);
        add_row(MAT_MIN, MODE_VEC, 1, 0, 0, -1, 0, 0, 0, 0, 0, 0);
        add_row(MAT_MAX, MODE_POINT, 0, 0, 0, C_MIN, 1,
                C_MAX, C_MAX, C_MAX, C_MAX, 0);
        add_row(MAT_MAX, MODE_VEC, C_MIN, 0, 0, 0, 1,
                C_MIN, C_MIN, C_MIN, C_MIN, 1);
        add_row(MAT_MAX, MODE_VEC, 1, -1, 32'sh0000_7FFF, -32'sh0000_8000, 0,
                0, 0, 0, 0, 0);
        add_row(MAT_MAX, MODE_POINT, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].mat != cur_mat) begin
                write_matrix(directed_rows[n].mat);
                cur_mat = directed_rows[n].mat;
            end
            push_vec(directed_rows[n]);
            sender_gap();
        end

        phase_mats[0] = MAT_SMALL;
        phase_mats[1] = MAT_FULL;
        phase_mats[2] = MAT_MIXED;
        phase_mats[3] = MAT_SMALL;
        phase_mats[4] = MAT_MIXED;
        phase_mats[5] = MAT_SMALL;
        for (int p = 0; p < 6; p++) begin
            write_matrix(phase_mats[p]);
            // Final stretch runs at full rate on both sides.
            if (p == 5)
                stalls_on = 1'b0;
            repeat (PHASE_VECS) begin
                row.mat   = phase_mats[p];
                row.mode  = t_vec_mode'(1'($urandom));
                row.x     = rand_comp();
                row.y     = rand_comp();
                row.z     = rand_comp();
                row.w     = rand_comp();
                row.fixed = 1'b0;
                push_vec(row);
                sender_gap();
            end
        end
        i_s_tvalid <= 1'b0;

        wait (expected_vertices.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_vertices.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
